>>> hw/rtl/u8u16_pkg.sv
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared widths, code point constants and the hex digit encoder for the
// UTF-8 to UTF-16BE hex transcoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

    localparam int BYTE_W = 8;
    localparam int HEX_W  = 7;
    localparam int CP_W   = 21;
    localparam int UNIT_W = 16;

    // UTF-16 units written to the output
    localparam logic [UNIT_W-1:0] BOM_UNIT       = 16'hFEFF;
    localparam logic [UNIT_W-1:0] REPL_UNIT      = 16'hFFFD;
    localparam logic [UNIT_W-1:0] HIGH_SURR_BASE = 16'hD800;
    localparam logic [UNIT_W-1:0] LOW_SURR_BASE  = 16'hDC00;

    // Code point limits
    localparam logic [CP_W-1:0] MAX_SCALAR = 21'h10FFFF;
    localparam logic [CP_W-1:0] SURR_FIRST = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_LAST  = 21'h00DFFF;
    localparam logic [CP_W-1:0] SUPP_BASE  = 21'h010000;
    localparam logic [CP_W-1:0] REPL_CP    = 21'h00FFFD;

    // ASCII codes of the hex digit set
    localparam logic [HEX_W-1:0] ASCII_ZERO = 7'h30;
    localparam logic [HEX_W-1:0] ASCII_NINE = 7'h39;
    localparam logic [HEX_W-1:0] ASCII_UA   = 7'h41;
    localparam logic [HEX_W-1:0] ASCII_UF   = 7'h46;

    function automatic logic [HEX_W-1:0] hex_ascii(input logic [3:0] nib);
        logic [HEX_W-1:0] ext;
        ext = {3'b000, nib};
        if (nib < 4'd10)
            return ASCII_ZERO + ext;
        else
            return ASCII_UA + ext - 7'd10;
    endfunction

endpackage

>>> hw/rtl/utf8_to_utf16be_hex.sv
// ----------------------------------------------------------------------------
// utf8_to_utf16be_hex
// Transcodes a UTF-8 byte stream into uppercase ASCII hex of UTF-16BE.
// ----------------------------------------------------------------------------
// Input channel: one UTF-8 byte per word (byte_value), last_of_string marks
// the final byte of a string. Output channel: one ASCII hex digit per word,
// most significant digit of each 16-bit unit first. last_of_run flags the
// final digit produced by one input byte, end_of_string the final digit of
// the string. Each string opens with FEFF; bad or cut sequences and
// out-of-range values give FFFD; supplementary code points give a pair.
// A byte produces 0, 4 or 8 digits (one or two units).
// A taken byte goes through the decoded job register, then the digit
// emitter, before out_valid rises. The emitter sends one digit per cycle
// while out_ready is high: 4 digits per unit, 4 per BMP character and 8
// for a supplementary character or the first character of a string.
// A decoded job register sits in front of the emitter, so the next byte is
// taken while the current digits are still going out. Bytes that complete
// nothing are taken at once when the job register is free.
// Reset clears the decoder (next byte opens a string) and drops all pending
// output. When out_ready is low the current digit holds and input stalls
// once the job register is full.
// ----------------------------------------------------------------------------
module utf8_to_utf16be_hex (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [u8u16_pkg::BYTE_W-1:0]  byte_value,
    input  logic                          last_of_string,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [u8u16_pkg::HEX_W-1:0]   hex_char,
    output logic                          last_of_run,
    output logic                          end_of_string
);
    import u8u16_pkg::*;

    // decoder state
    logic [CP_W-1:0]     part_reg, part_next;
    logic [1:0]          expect_reg, expect_next;
    logic                start_reg, start_next;

    // decoded job
    logic                job_valid_reg, job_valid_next;
    logic [2*UNIT_W-1:0] job_units_reg, job_units_next;
    logic                job_two_reg, job_two_next;
    logic                job_eos_reg, job_eos_next;

    // digit emitter
    logic                out_valid_reg, out_valid_next;
    logic [2*UNIT_W-1:0] ser_units_reg, ser_units_next;
    logic [2:0]          ser_idx_reg, ser_idx_next;
    logic                ser_two_reg, ser_two_next;
    logic                ser_eos_reg, ser_eos_next;

    logic                in_fire, out_fire, last_char, ser_free, job_take;

    // decode signals
    logic                is_cont, lead_ascii, lead_multi, lead_en;
    logic [CP_W-1:0]     lead_part, cont_cp;
    logic [1:0]          lead_exp;
    logic                pre_valid, cp_valid;
    logic [UNIT_W-1:0]   pre_unit;
    logic [CP_W-1:0]     cp_emit, cp_fix, supp_off;
    logic                cp_bad, cp_supp;
    logic [UNIT_W-1:0]   hi_unit, lo_unit;
    logic [2*UNIT_W-1:0] dec_units;
    logic                dec_two, dec_any;

    // ---------------------------------------------------------------- decode
    assign is_cont    = (byte_value[7:6] == 2'b10);
    assign lead_ascii = ~byte_value[7];
    assign cont_cp    = {part_reg[CP_W-7:0], byte_value[5:0]};

    always_comb
    begin
        lead_multi = 1'b1;
        lead_part  = '0;
        lead_exp   = 2'd0;
        priority if (byte_value[7:5] == 3'b110)
        begin
            lead_part = {16'd0, byte_value[4:0]};
            lead_exp  = 2'd1;
        end
        else if (byte_value[7:4] == 4'b1110)
        begin
            lead_part = {17'd0, byte_value[3:0]};
            lead_exp  = 2'd2;
        end
        else if (byte_value[7:3] == 5'b11110)
        begin
            lead_part = {18'd0, byte_value[2:0]};
            lead_exp  = 2'd3;
        end
        else
        begin
            lead_multi = 1'b0;
        end
    end

    always_comb
    begin
        pre_valid   = 1'b0;
        pre_unit    = BOM_UNIT;
        cp_valid    = 1'b0;
        cp_emit     = REPL_CP;
        lead_en     = 1'b0;
        part_next   = part_reg;
        expect_next = expect_reg;
        start_next  = start_reg;

        if (start_reg)
        begin
            pre_valid  = 1'b1;
            pre_unit   = BOM_UNIT;
            start_next = 1'b0;
        end

        if (expect_reg != 2'd0)
        begin
            if (is_cont)
            begin
                part_next   = cont_cp;
                expect_next = expect_reg - 2'd1;
                if (expect_reg == 2'd1)
                begin
                    cp_valid  = 1'b1;
                    cp_emit   = cont_cp;
                    part_next = '0;
                end
                else if (last_of_string)
                begin
                    cp_valid = 1'b1;
                end
            end
            else
            begin
                // broken sequence: replace it, then treat this byte as a lead
                pre_valid   = 1'b1;
                pre_unit    = REPL_UNIT;
                part_next   = '0;
                expect_next = 2'd0;
                lead_en     = 1'b1;
            end
        end
        else
        begin
            lead_en = 1'b1;
        end

        if (lead_en)
        begin
            priority if (lead_ascii)
            begin
                cp_valid = 1'b1;
                cp_emit  = {13'd0, byte_value};
            end
            else if (lead_multi)
            begin
                part_next   = lead_part;
                expect_next = lead_exp;
                cp_valid    = last_of_string;
            end
            else
            begin
                cp_valid = 1'b1;
            end
        end

        if (last_of_string)
        begin
            part_next   = '0;
            expect_next = 2'd0;
            start_next  = 1'b1;
        end
    end

    // code point to UTF-16 units
    assign cp_bad   = (cp_emit > MAX_SCALAR) ||
                      ((cp_emit >= SURR_FIRST) && (cp_emit <= SURR_LAST));
    assign cp_fix   = cp_bad ? REPL_CP : cp_emit;
    assign cp_supp  = (cp_fix[CP_W-1:UNIT_W] != '0);
    assign supp_off = cp_fix - SUPP_BASE;
    assign hi_unit  = HIGH_SURR_BASE + {6'd0, supp_off[19:10]};
    assign lo_unit  = LOW_SURR_BASE + {6'd0, supp_off[9:0]};

    always_comb
    begin
        priority if (pre_valid)
        begin
            dec_units = {pre_unit, cp_fix[UNIT_W-1:0]};
            dec_two   = cp_valid;
            dec_any   = 1'b1;
        end
        else if (cp_valid && cp_supp)
        begin
            dec_units = {hi_unit, lo_unit};
            dec_two   = 1'b1;
            dec_any   = 1'b1;
        end
        else
        begin
            dec_units = {cp_fix[UNIT_W-1:0], {UNIT_W{1'b0}}};
            dec_two   = 1'b0;
            dec_any   = cp_valid;
        end
    end

    // ---------------------------------------------------------- handshakes
    assign out_fire  = out_valid_reg && out_ready;
    assign last_char = (ser_idx_reg == (ser_two_reg ? 3'd7 : 3'd3));
    assign ser_free  = !out_valid_reg || (out_fire && last_char);
    assign job_take  = job_valid_reg && ser_free;
    assign in_ready  = !job_valid_reg || job_take;
    assign in_fire   = in_valid && in_ready;

    // ------------------------------------------------------------- job stage
    always_comb
    begin
        job_valid_next = job_valid_reg;
        job_units_next = job_units_reg;
        job_two_next   = job_two_reg;
        job_eos_next   = job_eos_reg;
        if (in_fire)
        begin
            job_valid_next = dec_any;
            job_units_next = dec_units;
            job_two_next   = dec_two;
            job_eos_next   = last_of_string;
        end
        else if (job_take)
        begin
            job_valid_next = 1'b0;
        end
    end

    // --------------------------------------------------------------- emitter
    always_comb
    begin
        out_valid_next = out_valid_reg;
        ser_units_next = ser_units_reg;
        ser_idx_next   = ser_idx_reg;
        ser_two_next   = ser_two_reg;
        ser_eos_next   = ser_eos_reg;
        if (job_take)
        begin
            out_valid_next = 1'b1;
            ser_units_next = job_units_reg;
            ser_idx_next   = 3'd0;
            ser_two_next   = job_two_reg;
            ser_eos_next   = job_eos_reg;
        end
        else if (out_fire)
        begin
            // advance to the next digit, or drop the run when done
            ser_units_next = {ser_units_reg[2*UNIT_W-5:0], 4'h0};
            ser_idx_next   = ser_idx_reg + 3'd1;
            if (last_char)
                out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            part_reg      <= '0;
            expect_reg    <= 2'd0;
            start_reg     <= 1'b1;
            job_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            ser_idx_reg   <= 3'd0;
        end
        else
        begin
            if (in_fire)
            begin
                part_reg   <= part_next;
                expect_reg <= expect_next;
                start_reg  <= start_next;
            end
            job_valid_reg <= job_valid_next;
            out_valid_reg <= out_valid_next;
            ser_idx_reg   <= ser_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_units_reg <= job_units_next;
        job_two_reg   <= job_two_next;
        job_eos_reg   <= job_eos_next;
        ser_units_reg <= ser_units_next;
        ser_two_reg   <= ser_two_next;
        ser_eos_reg   <= ser_eos_next;
    end

    assign out_valid     = out_valid_reg;
    assign hex_char      = hex_ascii(ser_units_reg[2*UNIT_W-1:2*UNIT_W-4]);
    assign last_of_run   = last_char;
    assign end_of_string = last_char && ser_eos_reg;

endmodule

>>> hw/rtl/u8u16_checker.sv
// ----------------------------------------------------------------------------
// u8u16_checker
// Port-level checks for the UTF-8 to UTF-16BE hex transcoder.
// ----------------------------------------------------------------------------
module u8u16_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic [u8u16_pkg::BYTE_W-1:0]  byte_value,
    input logic                          last_of_string,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [u8u16_pkg::HEX_W-1:0]   hex_char,
    input logic                          last_of_run,
    input logic                          end_of_string
);
    import u8u16_pkg::*;

    // a stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(hex_char) &&
        $stable(last_of_run) && $stable(end_of_string))
        else $error("output word changed while stalled");

    a_hex_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((hex_char >= ASCII_ZERO) && (hex_char <= ASCII_NINE)) ||
                      ((hex_char >= ASCII_UA) && (hex_char <= ASCII_UF)))
        else $error("hex_char is not an uppercase hex digit");

    a_eos_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_of_string |-> last_of_run)
        else $error("end_of_string without last_of_run");

    a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !out_valid)
        else $error("output valid straight out of reset");

endmodule

bind utf8_to_utf16be_hex u8u16_checker u_checker (.*);

>>> sim/utf8_to_utf16be_hex_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_utf16be_hex_test
// Self-checking bench for the UTF-8 to UTF-16BE hex transcoder. A queue of
// UTF-8 bytes feeds a valid/ready driver; a monitor decodes every accepted
// byte in its own decoder and checks each hex digit against the oldest one
// due. Directed strings cover the edge cases, then random strings follow
// with random gaps and stalls on both channels and one long output hold.
// ----------------------------------------------------------------------------
module utf8_to_utf16be_hex_test;

    import u8u16_pkg::*;

    localparam int HOLD_CYCLES   = 400;
    localparam int RANDOM_TARGET = 200;
    localparam int MAX_DIGITS    = 8;

    typedef struct {
        logic [BYTE_W-1:0] value;
        logic              last;
    } utf8_byte_t;

    typedef struct {
        logic [HEX_W-1:0] hex;
        logic             run_end;
        logic             str_end;
    } hex_digit_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [BYTE_W-1:0] byte_value;
    logic              last_of_string;
    logic              out_valid;
    logic              out_ready;
    logic [HEX_W-1:0]  hex_char;
    logic              last_of_run;
    logic              end_of_string;

    utf8_byte_t pending_bytes[$];
    hex_digit_t due_digits[$];
    utf8_byte_t next_byte;

    // decoder state of the bench
    logic [CP_W-1:0] code_acc;
    logic [1:0]      cont_left;
    logic            at_start;
    int              run_len;

    string hex_alphabet = "0123456789ABCDEF";

    int   fail_count  = 0;
    int   bytes_total = 0;
    int   bytes_taken = 0;
    int   bytes_sent  = 0;
    logic in_taken    = 1'b0;
    int   send_gap    = 0;
    int   ready_gap   = 0;
    int   rx_cycles   = 0;
    logic tx_steady   = 1'b0;
    logic rx_steady   = 1'b0;
    logic hold_on     = 1'b0;

    // bit 8 marks the last byte of a string
    logic [8:0] directed_bytes [29] = '{
        9'h141,
        9'h000, 9'h07F, 9'h0C3, 9'h0A9, 9'h0E2, 9'h082, 9'h1AC,
        9'h0F0, 9'h09F, 9'h098, 9'h080, 9'h0F4, 9'h08F, 9'h0BF, 9'h0BF,
        9'h0F4, 9'h090, 9'h080, 9'h180,
        9'h0ED, 9'h0A0, 9'h080, 9'h0FF, 9'h0E2, 9'h041, 9'h0C3, 9'h0E2, 9'h182
    };

    utf8_to_utf16be_hex dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .byte_value     (byte_value),
        .last_of_string (last_of_string),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .hex_char       (hex_char),
        .last_of_run    (last_of_run),
        .end_of_string  (end_of_string)
    );

    always #2 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic void emit_unit(input logic [UNIT_W-1:0] unit);
        hex_digit_t d;
        byte        ch;
        for (int s = 3; s >= 0; s--)
        begin
            if (run_len < MAX_DIGITS)
            begin
                ch        = hex_alphabet[unit[s*4 +: 4]];
                d.hex     = ch[6:0];
                d.run_end = 1'b0;
                d.str_end = 1'b0;
                due_digits = {due_digits, d};
                run_len++;
            end
        end
    endfunction

    function automatic void emit_code_point(input logic [CP_W-1:0] cp);
        logic [CP_W-1:0] v;
        if (cp > MAX_SCALAR || (cp >= SURR_FIRST && cp <= SURR_LAST))
            v = REPL_CP;
        else
            v = cp;
        if (v <= 21'h00FFFF)
            emit_unit(v[UNIT_W-1:0]);
        else
        begin
            v = v - SUPP_BASE;
            emit_unit(HIGH_SURR_BASE + {6'b0, v[19:10]});
            emit_unit(LOW_SURR_BASE + {6'b0, v[9:0]});
        end
    endfunction

    function automatic void open_lead(input logic [BYTE_W-1:0] b, input logic last);
        if (!b[7])
        begin
            emit_code_point({13'b0, b});
            return;
        end
        if (b[7:5] == 3'b110)
        begin
            code_acc  = {16'b0, b[4:0]};
            cont_left = 2'd1;
        end
        else if (b[7:4] == 4'b1110)
        begin
            code_acc  = {17'b0, b[3:0]};
            cont_left = 2'd2;
        end
        else if (b[7:3] == 5'b11110)
        begin
            code_acc  = {18'b0, b[2:0]};
            cont_left = 2'd3;
        end
        else
        begin
            emit_code_point(REPL_CP);
            return;
        end
        // a lead that ends the string is an unfinished sequence
        if (last)
        begin
            emit_code_point(REPL_CP);
            code_acc  = '0;
            cont_left = 2'd0;
        end
    endfunction

    function automatic void transcode_byte(input logic [BYTE_W-1:0] b, input logic last);
        run_len = 0;
        if (at_start)
        begin
            emit_unit(BOM_UNIT);
            at_start = 1'b0;
        end
        if (cont_left != 2'd0)
        begin
            if (b[7:6] == 2'b10)
            begin
                code_acc  = {code_acc[14:0], b[5:0]};
                cont_left = cont_left - 2'd1;
                if (cont_left == 2'd0)
                begin
                    emit_code_point(code_acc);
                    code_acc = '0;
                end
                else if (last)
                    emit_code_point(REPL_CP);
            end
            else
            begin
                // broken sequence: replace it, then decode this byte afresh
                emit_code_point(REPL_CP);
                code_acc  = '0;
                cont_left = 2'd0;
                open_lead(b, last);
            end
        end
        else
            open_lead(b, last);
        if (last)
        begin
            code_acc  = '0;
            cont_left = 2'd0;
            at_start  = 1'b1;
        end
        if (run_len > 0)
        begin
            due_digits[due_digits.size()-1].run_end = 1'b1;
            due_digits[due_digits.size()-1].str_end = last;
        end
    endfunction

    task automatic push_byte(input logic [BYTE_W-1:0] b, input logic last);
        utf8_byte_t item;
        item.value = b;
        item.last  = last;
        pending_bytes = {pending_bytes, item};
    endtask

    task automatic push_encoded(input logic [CP_W-1:0] cp, input int len, input int keep);
        logic [BYTE_W-1:0] seq [4];
        case (len)
            1: seq[0] = {1'b0, cp[6:0]};
            2:
            begin
                seq[0] = {3'b110, cp[10:6]};
                seq[1] = {2'b10, cp[5:0]};
            end
            3:
            begin
                seq[0] = {4'b1110, cp[15:12]};
                seq[1] = {2'b10, cp[11:6]};
                seq[2] = {2'b10, cp[5:0]};
            end
            default:
            begin
                seq[0] = {5'b11110, cp[20:18]};
                seq[1] = {2'b10, cp[17:12]};
                seq[2] = {2'b10, cp[11:6]};
                seq[3] = {2'b10, cp[5:0]};
            end
        endcase
        for (int k = 0; k < keep; k++)
            push_byte(seq[k], 1'b0);
    endtask

    task automatic push_random_string();
        int              n_chars;
        int              r;
        int              len;
        logic [CP_W-1:0] cp;
        logic            flip;
        n_chars = $urandom_range(1, 8);
        for (int i = 0; i < n_chars; i++)
        begin
            r  = $urandom_range(0, 99);
            cp = CP_W'($urandom_range(0, 21'h1FFFFF));
            if (r < 25)
                push_encoded(cp, 1, 1);
            else if (r < 45)
                push_encoded(cp, 2, 2);
            else if (r < 70)
                push_encoded(cp, 3, 3);
            else if (r < 85)
            begin
                // keep four-byte values near the top of the range half the time
                if ($urandom_range(0, 1) == 1)
                begin
                    flip = 1'($urandom_range(0, 1));
                    cp   = {5'b10000, cp[15:0]} ^ {4'b0, flip, 16'b0};
                end
                push_encoded(cp, 4, 4);
            end
            else if (r < 93)
            begin
                len = $urandom_range(2, 4);
                push_encoded(cp, len, int'($urandom_range(1, len - 1)));
            end
            else
                push_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
        end
        pending_bytes[pending_bytes.size()-1].last = 1'b1;
    endtask

    // sender: hold the word until taken, then gap or advance
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_taken)
                ;
            else if (send_gap > 0)
            begin
                in_valid <= 1'b0;
                send_gap--;
            end
            else if (pending_bytes.size() > 0)
            begin
                next_byte = pending_bytes.pop_front();
                byte_value     <= next_byte.value;
                last_of_string <= next_byte.last;
                in_valid       <= 1'b1;
                bytes_sent++;
                if (bytes_sent % 40 == 0)
                    tx_steady = ($urandom_range(0, 2) == 0);
                send_gap = tx_steady ? 0 : pick_gap();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver: random stalls, plus the long hold when asked
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            rx_cycles++;
            if (rx_cycles % 200 == 0)
                rx_steady = ($urandom_range(0, 2) == 0);
            if (hold_on)
                out_ready <= 1'b0;
            else if (ready_gap > 0)
            begin
                out_ready <= 1'b0;
                ready_gap--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!rx_steady && $urandom_range(0, 3) == 0)
                    ready_gap = pick_gap();
            end
        end
    end

    // monitor: decode taken bytes first, then check the digit on the output
    always @(posedge clk)
    begin
        hex_digit_t want;
        if (rst_n)
        begin
            in_taken <= in_valid && in_ready;
            if (in_valid && in_ready)
            begin
                transcode_byte(byte_value, last_of_string);
                bytes_taken++;
            end
            if (out_valid && out_ready)
            begin
                if (due_digits.size() == 0)
                begin
                    $error("unexpected digit %h on output", hex_char);
                    fail_count++;
                end
                else
                begin
                    want = due_digits.pop_front();
                    if (hex_char !== want.hex)
                    begin
                        $error("hex_char: expected %h, got %h", want.hex, hex_char);
                        fail_count++;
                    end
                    if (last_of_run !== want.run_end)
                    begin
                        $error("last_of_run: expected %b, got %b", want.run_end, last_of_run);
                        fail_count++;
                    end
                    if (end_of_string !== want.str_end)
                    begin
                        $error("end_of_string: expected %b, got %b",
                               want.str_end, end_of_string);
                        fail_count++;
                    end
                end
            end
        end
    end

    // long output hold while the sender keeps offering bytes
    initial
    begin
        while (bytes_taken < 80)
            @(posedge clk);
        hold_on = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        byte_value     = '0;
        last_of_string = 1'b0;
        out_ready      = 1'b0;
        code_acc       = '0;
        cont_left      = 2'd0;
        at_start       = 1'b1;
        run_len        = 0;

        foreach (directed_bytes[i])
            push_byte(directed_bytes[i][7:0], directed_bytes[i][8]);
        while (pending_bytes.size() < RANDOM_TARGET)
            push_random_string();
        bytes_total = pending_bytes.size();

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (bytes_taken < bytes_total)
            @(posedge clk);
        while (due_digits.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (fail_count == 0 && due_digits.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
